// ===== rtl/core/hts_pkg.sv =====
package hts_pkg;

    // scan modes
    localparam logic [3:0] MODE_TEXT    = 4'd0;
    localparam logic [3:0] MODE_PREFIX  = 4'd1;
    localparam logic [3:0] MODE_TAG     = 4'd2;
    localparam logic [3:0] MODE_COMMENT = 4'd3;
    localparam logic [3:0] MODE_STYLE   = 4'd4;
    localparam logic [3:0] MODE_SCRIPT  = 4'd5;
    localparam logic [3:0] MODE_GT      = 4'd6;

    // prefix candidate bits
    localparam int CAND_COMMENT = 0;
    localparam int CAND_STYLE   = 1;
    localparam int CAND_SCRIPT  = 2;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       window_last;
    } hts_in_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_byte;
        logic       window_end;
    } hts_out_t;

    typedef struct packed {
        logic [3:0] scan_mode;
        logic [2:0] match_progress;
        logic [2:0] prefix_alive;
        logic       last_was_space;
    } hts_state_t;

    localparam hts_state_t STATE_RESET = '{
        scan_mode:      MODE_TEXT,
        match_progress: 3'd0,
        prefix_alive:   3'd0,
        last_was_space: 1'b0
    };

    function automatic logic [7:0] fold(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'd32;
        end
        return b;
    endfunction

    function automatic logic is_collapse_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_skip_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    // pattern characters; only read where the index is in range
    function automatic logic [7:0] comment_open_char(input logic [2:0] p);
        case (p)
            3'd0:    return 8'h21; // !
            default: return CHAR_DASH;
        endcase
    endfunction

    function automatic logic [7:0] style_open_char(input logic [2:0] p);
        case (p)
            3'd0:    return 8'h73; // s
            3'd1:    return 8'h74; // t
            3'd2:    return 8'h79; // y
            3'd3:    return 8'h6C; // l
            default: return 8'h65; // e
        endcase
    endfunction

    function automatic logic [7:0] script_open_char(input logic [2:0] p);
        case (p)
            3'd0:    return 8'h73; // s
            3'd1:    return 8'h63; // c
            3'd2:    return 8'h72; // r
            3'd3:    return 8'h69; // i
            3'd4:    return 8'h70; // p
            default: return 8'h74; // t
        endcase
    endfunction

    function automatic logic [7:0] style_close_char(input logic [2:0] p);
        case (p)
            3'd0:    return CHAR_LT;
            3'd1:    return 8'h2F; // /
            default: return style_open_char(p - 3'd2);
        endcase
    endfunction

    function automatic logic [7:0] script_close_char(input logic [2:0] p);
        case (p)
            3'd0:    return CHAR_LT;
            3'd1:    return 8'h2F; // /
            default: return script_open_char(p - 3'd2);
        endcase
    endfunction

endpackage

// ===== rtl/core/hts_step.sv =====
module hts_step
    import hts_pkg::*;
(
    input  hts_state_t state_cur,
    input  hts_in_t    item_in,
    output hts_state_t state_next,
    output hts_out_t   item_out
);

    logic [7:0] b;
    logic [7:0] lb;
    logic [2:0] p;
    logic [2:0] alive;
    logic       close_hit;
    logic       close_done;
    hts_state_t st;

    assign b  = item_in.in_byte;
    assign lb = fold(item_in.in_byte);
    assign p  = state_cur.match_progress;

    // surviving prefix candidates after this byte
    always_comb begin
        alive = state_cur.prefix_alive;
        if (!(p < 3'd3 && b == comment_open_char(p))) begin
            alive[CAND_COMMENT] = 1'b0;
        end
        if (!(p < 3'd5 && lb == style_open_char(p))) begin
            alive[CAND_STYLE] = 1'b0;
        end
        if (!(p < 3'd6 && lb == script_open_char(p))) begin
            alive[CAND_SCRIPT] = 1'b0;
        end
    end

    // closing tag match for style and script blocks
    always_comb begin
        if (state_cur.scan_mode == MODE_STYLE) begin
            close_hit  = (p < 3'd7) && (lb == style_close_char(p));
            close_done = (p == 3'd6);
        end else begin
            close_hit  = (lb == script_close_char(p));
            close_done = (p == 3'd7);
        end
    end

    always_comb begin
        st       = state_cur;
        item_out = '0;
        item_out.window_end = item_in.window_last;

        unique case (state_cur.scan_mode)
            MODE_PREFIX: begin
                if (!(p == 3'd0 && is_skip_space(b))) begin
                    if (alive[CAND_COMMENT] && p == 3'd2) begin
                        st.scan_mode      = MODE_COMMENT;
                        st.match_progress = 3'd0;
                        st.prefix_alive   = 3'd0;
                    end else if (alive[CAND_STYLE] && p == 3'd4) begin
                        st.scan_mode      = MODE_STYLE;
                        st.match_progress = 3'd0;
                        st.prefix_alive   = 3'd0;
                    end else if (alive[CAND_SCRIPT] && p == 3'd5) begin
                        st.scan_mode      = MODE_SCRIPT;
                        st.match_progress = 3'd0;
                        st.prefix_alive   = 3'd0;
                    end else if (alive == 3'd0) begin
                        st.scan_mode      = (b == CHAR_GT) ? MODE_TEXT : MODE_TAG;
                        st.match_progress = 3'd0;
                        st.prefix_alive   = 3'd0;
                    end else begin
                        st.match_progress = p + 3'd1;
                        st.prefix_alive   = alive;
                    end
                end
            end
            MODE_TAG, MODE_GT: begin
                if (b == CHAR_GT) begin
                    st.scan_mode = MODE_TEXT;
                end
            end
            MODE_COMMENT: begin
                if (b == CHAR_DASH) begin
                    if (p < 3'd2) begin
                        st.match_progress = p + 3'd1;
                    end
                end else if (b == CHAR_GT && p >= 3'd2) begin
                    st.scan_mode      = MODE_TEXT;
                    st.match_progress = 3'd0;
                end else begin
                    st.match_progress = 3'd0;
                end
            end
            MODE_STYLE, MODE_SCRIPT: begin
                if (close_hit) begin
                    if (close_done) begin
                        st.scan_mode      = MODE_GT;
                        st.match_progress = 3'd0;
                    end else begin
                        st.match_progress = p + 3'd1;
                    end
                end else begin
                    st.match_progress = {2'b00, b == CHAR_LT};
                end
            end
            default: begin
                st.scan_mode = MODE_TEXT;
                if (b == CHAR_LT) begin
                    st.scan_mode      = MODE_PREFIX;
                    st.match_progress = 3'd0;
                    st.prefix_alive   = 3'b111;
                end else if (is_collapse_space(b)) begin
                    if (!state_cur.last_was_space) begin
                        st.last_was_space   = 1'b1;
                        item_out.char_valid = 1'b1;
                        item_out.out_byte   = CHAR_SPACE;
                    end
                end else begin
                    item_out.char_valid = 1'b1;
                    item_out.out_byte   = b;
                    st.last_was_space   = 1'b0;
                end
            end
        endcase

        // window end drops every open match
        state_next = item_in.window_last ? STATE_RESET : st;
    end

endmodule

// ===== rtl/core/html_tag_stripper.sv =====
// Streaming markup stripper: one text byte in per item, one result out per item.
// Comments, style and script blocks and plain tags are dropped, whitespace runs
// outside markup become one space, and the window-last byte returns the scanner
// to its reset state. An item is accepted every clock cycle while the output
// register is empty or being drained; its result appears in the output register
// in the cycle after acceptance, and throughput is one item per cycle, set by
// the single scanner state register updated on each accepted byte.
module html_tag_stripper
    import hts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hts_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hts_out_t m_data
);

    hts_state_t state_reg;
    hts_state_t state_next;
    hts_out_t   out_next;
    hts_out_t   out_reg;
    logic       valid_reg;
    logic       accept;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    hts_step u_step (
        .state_cur  (state_reg),
        .item_in    (s_data),
        .state_next (state_next),
        .item_out   (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/hts_checker.sv =====
module hts_checker
    import hts_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input hts_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input hts_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // every accepted item yields a result next cycle
    a_item_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    // markup opener never reaches the output
    a_no_lt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.char_valid |-> m_data.out_byte != CHAR_LT)
        else $error("tag opener emitted");

    // whitespace is always collapsed to a plain space
    a_ws_folded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.char_valid |->
            !(m_data.out_byte >= 8'h09 && m_data.out_byte <= 8'h0D))
        else $error("raw whitespace emitted");

    // no two spaces back to back within a window
    a_no_double_space: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(m_valid && m_ready) && $past(m_data.char_valid)
            && $past(m_data.out_byte) == CHAR_SPACE && !$past(m_data.window_end)
            && m_valid && m_data.char_valid
        |-> m_data.out_byte != CHAR_SPACE)
        else $error("whitespace run not collapsed");

endmodule

bind html_tag_stripper hts_checker u_hts_checker (.*);

// ===== sim/tb_html_tag_stripper.sv =====
module tb_html_tag_stripper;
    timeunit 1ns;
    timeprecision 1ps;

    import hts_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 150;

    // markup patterns, first character in the highest used byte
    localparam logic [63:0] PAT_COMMENT_OPEN = "!--";
    localparam logic [63:0] PAT_STYLE_OPEN   = "style";
    localparam logic [63:0] PAT_SCRIPT_OPEN  = "script";
    localparam logic [63:0] PAT_STYLE_CLOSE  = "</style";
    localparam logic [63:0] PAT_SCRIPT_CLOSE = "</script";

    localparam string TAG_BLANKS = "\011\012\015\040";
    localparam string TEXT_CHARS = "Hello wORLD,\011\012\013\014\015\040  0~\177\200\377";

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
        logic       typed;
        logic       want_valid;
        logic [7:0] want_byte;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hts_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hts_out_t m_data;

    // predictor copy of the scanner
    logic [3:0] mode_q;
    logic [2:0] match_cnt;
    logic [2:0] cand_live;
    logic       space_seen;

    hts_out_t   stripped_q[$];
    logic [7:0] doc_q[$];
    int         mismatch_count = 0;
    int         items_sent     = 0;
    bit         calm           = 1'b0;
    bit         hold_off_req   = 1'b0;

    dir_row_t directed_rows [26] = '{
        {8'h41, 1'b0, 1'b1, 1'b1, 8'h41},           // 'A' right after reset
        {8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF},
        {8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
        {8'h0D, 1'b0, 1'b1, 1'b1, CHAR_SPACE},      // whitespace becomes one space
        {8'h0C, 1'b0, 1'b1, 1'b0, 8'h00},           // rest of the run is dropped
        {CHAR_LT, 1'b0, 1'b1, 1'b0, 8'h00},
        {CHAR_GT, 1'b0, 1'b0, 1'b0, 8'h00},         // prefix fails on '>', tag ends
        {CHAR_LT, 1'b0, 1'b0, 1'b0, 8'h00},
        {8'h0C, 1'b0, 1'b0, 1'b0, 8'h00},           // form feed is not skipped after '<'
        {CHAR_GT, 1'b0, 1'b0, 1'b0, 8'h00},
        {CHAR_LT, 1'b0, 1'b0, 1'b0, 8'h00},
        {8'h21, 1'b0, 1'b0, 1'b0, 8'h00},           // comment open
        {CHAR_DASH, 1'b0, 1'b0, 1'b0, 8'h00},
        {CHAR_DASH, 1'b0, 1'b0, 1'b0, 8'h00},
        {CHAR_GT, 1'b0, 1'b0, 1'b0, 8'h00},         // '>' alone does not close it
        {CHAR_DASH, 1'b0, 1'b0, 1'b0, 8'h00},
        {CHAR_DASH, 1'b0, 1'b0, 1'b0, 8'h00},
        {CHAR_GT, 1'b0, 1'b0, 1'b0, 8'h00},
        {CHAR_LT, 1'b0, 1'b0, 1'b0, 8'h00},
        {8'h09, 1'b0, 1'b0, 1'b0, 8'h00},           // tab skipped before the name
        {8'h53, 1'b0, 1'b0, 1'b0, 8'h00},           // "StYle" in mixed case
        {8'h74, 1'b0, 1'b0, 1'b0, 8'h00},
        {8'h59, 1'b0, 1'b0, 1'b0, 8'h00},
        {8'h6C, 1'b0, 1'b0, 1'b0, 8'h00},
        {8'h65, 1'b0, 1'b0, 1'b0, 8'h00},
        {8'h7A, 1'b1, 1'b0, 1'b0, 8'h00}            // window ends inside the style block
    };

    html_tag_stripper dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic bit is_run_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_tag_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic [7:0] pat_char(input logic [63:0] pat, input int len, input int idx);
        if (idx >= len) begin
            return 8'h00;
        end
        return pat[8*(len-1-idx) +: 8];
    endfunction

    function automatic void clear_scan();
        mode_q     = MODE_TEXT;
        match_cnt  = 3'd0;
        cand_live  = 3'd0;
        space_seen = 1'b0;
    endfunction

    // closing tag search inside a style or script block
    function automatic void close_search(input logic [7:0] c, input logic [63:0] pat,
                                         input int len);
        int p;
        p = match_cnt;
        if (p < len && to_lower(c) == pat_char(pat, len, p)) begin
            p++;
            if (p >= len) begin
                mode_q = MODE_GT;
                p = 0;
            end
        end else begin
            p = (c == CHAR_LT) ? 1 : 0;
        end
        match_cnt = 3'(p);
    endfunction

    function automatic hts_out_t strip_step(input hts_in_t in_item);
        hts_out_t   res;
        logic [7:0] c;
        logic [7:0] lc;
        logic [2:0] live;
        int         p;
        c = in_item.in_byte;
        lc = to_lower(c);
        p = match_cnt;
        res = '0;
        res.window_end = in_item.window_last;
        case (mode_q)
            MODE_PREFIX: begin
                if (!(p == 0 && is_tag_space(c))) begin
                    live = cand_live;
                    if (!(p < 3 && c == pat_char(PAT_COMMENT_OPEN, 3, p))) begin
                        live[CAND_COMMENT] = 1'b0;
                    end
                    if (!(p < 5 && lc == pat_char(PAT_STYLE_OPEN, 5, p))) begin
                        live[CAND_STYLE] = 1'b0;
                    end
                    if (!(p < 6 && lc == pat_char(PAT_SCRIPT_OPEN, 6, p))) begin
                        live[CAND_SCRIPT] = 1'b0;
                    end
                    match_cnt = 3'd0;
                    cand_live = 3'd0;
                    if (live[CAND_COMMENT] && p == 2) begin
                        mode_q = MODE_COMMENT;
                    end else if (live[CAND_STYLE] && p == 4) begin
                        mode_q = MODE_STYLE;
                    end else if (live[CAND_SCRIPT] && p == 5) begin
                        mode_q = MODE_SCRIPT;
                    end else if (live == 3'd0) begin
                        mode_q = (c == CHAR_GT) ? MODE_TEXT : MODE_TAG;
                    end else begin
                        match_cnt = 3'(p + 1);
                        cand_live = live;
                    end
                end
            end
            MODE_TAG, MODE_GT: begin
                if (c == CHAR_GT) begin
                    mode_q = MODE_TEXT;
                end
            end
            MODE_COMMENT: begin
                if (c == CHAR_DASH) begin
                    if (match_cnt < 3'd2) begin
                        match_cnt = match_cnt + 3'd1;
                    end
                end else if (c == CHAR_GT && match_cnt >= 3'd2) begin
                    mode_q = MODE_TEXT;
                    match_cnt = 3'd0;
                end else begin
                    match_cnt = 3'd0;
                end
            end
            MODE_STYLE: close_search(c, PAT_STYLE_CLOSE, 7);
            MODE_SCRIPT: close_search(c, PAT_SCRIPT_CLOSE, 8);
            default: begin
                mode_q = MODE_TEXT;
                if (c == CHAR_LT) begin
                    mode_q = MODE_PREFIX;
                    match_cnt = 3'd0;
                    cand_live = 3'b111;
                end else if (is_run_space(c)) begin
                    if (!space_seen) begin
                        space_seen = 1'b1;
                        res.char_valid = 1'b1;
                        res.out_byte = CHAR_SPACE;
                    end
                end else begin
                    res.char_valid = 1'b1;
                    res.out_byte = c;
                    space_seen = 1'b0;
                end
            end
        endcase
        if (in_item.window_last) begin
            clear_scan();
        end
        return res;
    endfunction

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    task automatic add_word(input string s, input bit mixed);
        for (int i = 0; i < s.len(); i++) begin
            doc_q.insert(doc_q.size(), mixed ? mix_case(s[i]) : s[i]);
        end
    endtask

    task automatic add_pick(input string alphabet, input int n);
        for (int i = 0; i < n; i++) begin
            doc_q.insert(doc_q.size(), alphabet[$urandom_range(alphabet.len() - 1)]);
        end
    endtask

    task automatic add_raw_block(input string name, input string body);
        add_word("<", 1'b0);
        add_pick(TAG_BLANKS, $urandom_range(0, 2));
        add_word(name, 1'b1);
        add_pick(body, $urandom_range(0, 12));
        add_word("</", 1'b0);
        add_word(name, 1'b1);
        add_pick(" x", $urandom_range(0, 1));
        add_word(">", 1'b0);
    endtask

    // one window of document text: plain text, well-formed markup, some near misses and noise
    task automatic build_window();
        int n;
        doc_q.delete();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_pick(TEXT_CHARS, $urandom_range(1, 8));
                3: begin
                    add_word("<", 1'b0);
                    add_pick(TAG_BLANKS, $urandom_range(0, 2));
                    add_word("!--", 1'b0);
                    add_pick("-x> a", $urandom_range(0, 8));
                    add_word("-->", 1'b0);
                end
                4: add_raw_block("style", "<>/styleSTYLE a");
                5: add_raw_block("script", "<>/scriptSCRIPT a");
                6: begin
                    add_word("<", 1'b0);
                    add_pick(TAG_BLANKS, $urandom_range(0, 2));
                    add_pick("abpdivSPAN/", $urandom_range(1, 4));
                    add_pick(" =\"x'", $urandom_range(0, 4));
                    add_word(">", 1'b0);
                end
                7: begin
                    case ($urandom_range(0, 5))
                        0: add_word("<scrip>", 1'b1);
                        1: add_word("<!-x>", 1'b0);
                        2: add_word("<!->", 1'b0);
                        3: add_word("<sty le>", 1'b1);
                        4: add_word("<>", 1'b0);
                        default: add_word("</style>", 1'b1);
                    endcase
                end
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        doc_q.insert(doc_q.size(), 8'($urandom_range(255)));
                    end
                end
            endcase
        end
        // sometimes cut the window short, leaving markup open
        if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, doc_q.size());
            while (doc_q.size() > n) doc_q.delete(doc_q.size() - 1);
        end
    endtask

    task automatic send_item(input hts_in_t in_item, input bit typed, input hts_out_t typed_res);
        hts_out_t res;
        while (!calm && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= in_item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = strip_step(in_item);
        stripped_q.insert(stripped_q.size(), typed ? typed_res : res);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (stripped_q.size() != 0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
            end
            m_ready <= (!calm && $urandom_range(99) < 26) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        hts_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stripped_q.size() == 0) begin
                $error("result with no item pending: %h", m_data);
                mismatch_count++;
            end else begin
                want = stripped_q.pop_front();
                if (m_data.char_valid !== want.char_valid) begin
                    $error("char_valid: expected %0d, got %0d", want.char_valid,
                           m_data.char_valid);
                    mismatch_count++;
                end
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte,
                           m_data.out_byte);
                    mismatch_count++;
                end
                if (m_data.window_end !== want.window_end) begin
                    $error("window_end: expected %0d, got %0d", want.window_end,
                           m_data.window_end);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        dir_row_t row;
        hts_in_t  next_in;
        hts_out_t typed_res;
        bit       drained;
        drained = 1'b0;
        clear_scan();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            next_in.in_byte = row.in_byte;
            next_in.window_last = row.last;
            typed_res.char_valid = row.want_valid;
            typed_res.out_byte = row.want_byte;
            typed_res.window_end = row.last;
            send_item(next_in, row.typed, typed_res);
        end
        drain_results();

        while (items_sent < RANDOM_ITEMS) begin
            build_window();
            for (int i = 0; i < doc_q.size(); i++) begin
                calm = (items_sent >= 700 && items_sent < 1000);
                if (items_sent == 400) begin
                    hold_off_req = 1'b1;
                end
                next_in.in_byte = doc_q[i];
                next_in.window_last = (i == doc_q.size() - 1);
                send_item(next_in, 1'b0, '0);
                items_sent++;
            end
            if (!drained && items_sent >= 1000) begin
                drain_results();
                drained = 1'b1;
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (stripped_q.size() != 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hts_pkg.sv
rtl/core/hts_step.sv
rtl/core/html_tag_stripper.sv
rtl/core/hts_checker.sv
sim/tb_html_tag_stripper.sv
